[rtl/pvf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the PCM volume and fade-in unit.
// No dependencies; imported by every module of the block.
package pvf_pkg;

    // gain precision: Q15, one gain bit per serial step
    localparam int GAIN_BITS = 15;
    localparam int SAMPLE_BITS = 16;
    localparam int VOL_UNITY = 100;

    // register indexes of the configuration port
    localparam logic REG_VOLUME = 1'b0;
    localparam logic REG_FADE_LEN = 1'b1;

    typedef logic [GAIN_BITS-1:0] gain_t;
    typedef gain_t vol_table_t [128];

    // controls of one serial multiplier lane
    typedef struct packed {
        logic load;
        logic step;
        logic gbit;
    } mul_ctrl_t;

    // controls of the serial divider
    typedef struct packed {
        logic load;
        logic step;
        logic zero;
    } div_ctrl_t;

    // quadratic taper floor(v*v*32768/10000) below VOL_UNITY, zero from there up; evaluated at elaboration
    function automatic vol_table_t build_vol_table();
        vol_table_t t;
        for (int i = 0; i < 128; i++) begin
            if (i < VOL_UNITY) begin
                t[i] = GAIN_BITS'((i * i * 32768) / 10000);
            end else begin
                t[i] = '0;
            end
        end
        return t;
    endfunction

    localparam vol_table_t VOL_GAIN = build_vol_table();

endpackage

[rtl/pvf_mul.sv]
`timescale 1ns / 1ps
// Bit-serial signed sample by Q15 gain multiplier, LSB of the gain first.
// Depends on pvf_pkg for the control struct.
module pvf_mul import pvf_pkg::*; (
    input  logic                          aclk,
    input  mul_ctrl_t                     ctrl,
    input  logic signed [SAMPLE_BITS-1:0] load_value,
    output logic signed [SAMPLE_BITS-1:0] operand,
    output logic signed [SAMPLE_BITS-1:0] product
);

    logic signed [SAMPLE_BITS-1:0] s_reg;
    logic signed [SAMPLE_BITS+1:0] acc_reg;
    logic signed [SAMPLE_BITS+1:0] acc_sum;
    logic signed [SAMPLE_BITS+1:0] acc_next;

    // add the sample for a set gain bit, then halve with floor
    always_comb begin
        acc_sum  = acc_reg + (ctrl.gbit ? {{2{s_reg[SAMPLE_BITS-1]}}, s_reg} : '0);
        acc_next = acc_sum >>> 1;
    end

    // load the operand or advance one gain bit
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            s_reg   <= load_value;
            acc_reg <= '0;
        end else if (ctrl.step) begin
            acc_reg <= acc_next;
        end
    end

    assign operand = s_reg;
    assign product = acc_reg[SAMPLE_BITS-1:0];

endmodule

[rtl/pvf_div.sv]
`timescale 1ns / 1ps
// Restoring bit-serial divider for the Q15 fade gain floor(num*32768/den).
// Depends on pvf_pkg; the quotient fits 15 bits only if num is below den.
module pvf_div import pvf_pkg::*; (
    input  logic                   aclk,
    input  div_ctrl_t              ctrl,
    input  logic [SAMPLE_BITS-1:0] num,
    input  logic [SAMPLE_BITS-1:0] den,
    output gain_t                  quotient
);

    logic [SAMPLE_BITS-1:0] rem_reg;
    logic [SAMPLE_BITS-1:0] den_reg;
    logic                   zero_reg;
    gain_t                  quo_reg;
    logic [SAMPLE_BITS:0]   rem_dbl;
    logic                   qbit;
    logic [SAMPLE_BITS:0]   rem_sub;

    // shift the remainder and try one subtraction
    always_comb begin
        rem_dbl = {rem_reg, 1'b0};
        qbit    = !zero_reg && (rem_dbl >= {1'b0, den_reg});
        rem_sub = rem_dbl - {1'b0, den_reg};
    end

    // load operands or produce one quotient bit, MSB first
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rem_reg  <= num;
            den_reg  <= den;
            zero_reg <= ctrl.zero;
            quo_reg  <= '0;
        end else if (ctrl.step) begin
            rem_reg <= qbit ? rem_sub[SAMPLE_BITS-1:0] : rem_dbl[SAMPLE_BITS-1:0];
            quo_reg <= {quo_reg[GAIN_BITS-2:0], qbit};
        end
    end

    assign quotient = quo_reg;

endmodule

[rtl/pcm_volume_and_fade_in_unit.sv]
`timescale 1ns / 1ps
// Top level of the PCM volume and fade-in unit: sequencer, registers, output stage.
// Depends on pvf_pkg, pvf_mul and pvf_div.
//
//  channel | direction | fields (low bit first)
//  s_      | in        | tdata: left_sample[15:0], right_sample[31:16];
//          |           | tuser: mono_source[0], track_start[1]
//  m_      | out       | tdata: left_out[15:0], right_out[31:16]
//  APB     | in        | 0x0 volume_level[6:0], 0x4 fade_length[15:0]
//
// Each pair passes through one state to accept, 15 volume multiply steps (the fade
// divider runs alongside), one transfer, 15 fade multiply steps, one to deliver.
// The serial multiplier lanes and the divider work one bit per cycle.
// Reset (aresetn low, synchronous) clears the fade counter and loads volume 70,
// fade length 4410. A finished pair waits in the output register while the next
// is accepted; a second finished pair holds until the first is taken.
module pcm_volume_and_fade_in_unit import pvf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input samples
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // left_sample[15:0], right_sample[31:16]
    input  logic [1:0]  s_tuser,  // mono_source[0], track_start[1]
    // output samples
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // left_out[15:0], right_out[31:16]
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_VOL  = 3'd1;
    localparam logic [2:0] ST_XFER = 3'd2;
    localparam logic [2:0] ST_FADE = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam int CNT_W = $clog2(GAIN_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_BITS - 1);

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    gain_t                  gain_reg, gain_next;
    logic                   vol_bypass_reg, vol_bypass_next;
    logic                   fade_act_reg, fade_act_next;
    logic [SAMPLE_BITS-1:0] fade_rem_reg, fade_rem_next;
    logic [6:0]             vol_reg;
    logic [SAMPLE_BITS-1:0] flen_reg;
    logic [31:0]            out_data_reg, out_data_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   s_accept;
    logic                   cfg_write;
    logic [SAMPLE_BITS-1:0] rem_eff;
    logic signed [SAMPLE_BITS-1:0] in_left, in_right;
    mul_ctrl_t              mul_ctrl;
    div_ctrl_t              div_ctrl;
    logic signed [SAMPLE_BITS-1:0] left_load, right_load;
    logic signed [SAMPLE_BITS-1:0] left_opnd, right_opnd, left_prod, right_prod;
    gain_t                  fade_gain;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_reg  <= 7'd70;
            flen_reg <= 16'd4410;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_VOLUME:   vol_reg  <= pwdata[6:0];
                REG_FADE_LEN: flen_reg <= pwdata[15:0];
                default:      ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[2])
            REG_VOLUME:   prdata = {25'd0, vol_reg};
            REG_FADE_LEN: prdata = {16'd0, flen_reg};
            default:      prdata = '0;
        endcase
    end

    // input decode at accept
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_left  = s_tdata[15:0];
    assign in_right = s_tuser[0] ? s_tdata[15:0] : s_tdata[31:16];
    assign rem_eff  = s_tuser[1] ? flen_reg : fade_rem_reg;

    // operand selection for the lanes
    always_comb begin
        if (state_reg == ST_IDLE) begin
            left_load  = in_left;
            right_load = in_right;
        end else begin
            left_load  = vol_bypass_reg ? left_opnd  : left_prod;
            right_load = vol_bypass_reg ? right_opnd : right_prod;
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        gain_next       = gain_reg;
        vol_bypass_next = vol_bypass_reg;
        fade_act_next   = fade_act_reg;
        fade_rem_next   = fade_rem_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        mul_ctrl        = '0;
        div_ctrl        = '0;
        mul_ctrl.gbit   = gain_reg[0];
        div_ctrl.zero   = !(rem_eff < flen_reg);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    mul_ctrl.load   = 1'b1;
                    div_ctrl.load   = 1'b1;
                    gain_next       = VOL_GAIN[vol_reg];
                    vol_bypass_next = (vol_reg >= 7'(VOL_UNITY));
                    fade_act_next   = (rem_eff != '0);
                    fade_rem_next   = (rem_eff != '0) ? rem_eff - 16'd1 : rem_eff;
                    cnt_next        = '0;
                    state_next      = ST_VOL;
                end
            end
            ST_VOL: begin
                mul_ctrl.step = 1'b1;
                div_ctrl.step = 1'b1;
                gain_next     = gain_reg >> 1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_XFER;
                end
            end
            ST_XFER: begin
                mul_ctrl.load = 1'b1;
                gain_next     = fade_gain;
                cnt_next      = '0;
                state_next    = ST_FADE;
            end
            ST_FADE: begin
                mul_ctrl.step = 1'b1;
                gain_next     = gain_reg >> 1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_data_next[15:0]  = fade_act_reg ? left_prod  : left_opnd;
                    out_data_next[31:16] = fade_act_reg ? right_prod : right_opnd;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fade_rem_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fade_rem_reg  <= fade_rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gain_reg       <= gain_next;
        vol_bypass_reg <= vol_bypass_next;
        fade_act_reg   <= fade_act_next;
        out_data_reg   <= out_data_next;
    end

    // datapath units
    pvf_mul u_mul_left (
        .aclk       (aclk),
        .ctrl       (mul_ctrl),
        .load_value (left_load),
        .operand    (left_opnd),
        .product    (left_prod)
    );

    pvf_mul u_mul_right (
        .aclk       (aclk),
        .ctrl       (mul_ctrl),
        .load_value (right_load),
        .operand    (right_opnd),
        .product    (right_prod)
    );

    pvf_div u_div (
        .aclk     (aclk),
        .ctrl     (div_ctrl),
        .num      (flen_reg - rem_eff),
        .den      (flen_reg),
        .quotient (fade_gain)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // while stepping, the counter never runs past the last gain bit
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VOL || state_reg == ST_FADE) |-> cnt_reg <= CNT_LAST)
        else $error("step counter out of range");

    // an active fade counts down by one on each transaction
    a_fade_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_tuser[1] && fade_rem_reg != '0)
        |=> fade_rem_reg == $past(fade_rem_reg) - 16'd1)
        else $error("fade counter did not decrement");

    // a result only appears out of the delivery state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) && state_reg != ST_DONE |=> !m_tvalid)
        else $error("result appeared without a finished transaction");

endmodule
